// ===== rtl/core/fht_pkg.sv =====
package fht_pkg;

    // Command codes carried in the cmd field
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Configuration register indexes
    localparam logic REG_ENTRY_LIMIT = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    localparam logic [10:0] LIMIT_RESET   = 11'd1024;
    localparam logic [30:0] TIMEOUT_RESET = 31'd300;
    localparam logic [31:0] HASH_SEED     = 32'd5381;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic        mac_present;
        logic [47:0] source_mac;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  entry_index;
        logic [47:0] entry_mac;
        logic [31:0] entry_created;
        logic [10:0] live_count;
        logic [10:0] removed_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_HEAD,
        S_LOAD,
        S_LK_WALK,
        S_INS_WRITE,
        S_EX_WALK,
        S_DONE
    } fht_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step_clr;
        logic hash_step;
        logic mod_step;
        logic head_to_cur;
        logic lk_walk;
        logic ins_write;
        logic ins_full;
        logic ex_walk;
        logic bkt_inc;
        logic out_load;
        logic clr_step;
    } fht_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       hash_last;
        logic       mod_last;
        logic       head_end;
        logic       hit;
        logic       next_end;
        logic       bkt_last;
        logic       full;
        logic       out_free;
        logic       clr_last;
        logic [1:0] op;
    } fht_stat_t;

endpackage

// ===== rtl/core/flow_hash_table.sv =====
// Channel   Signals                          Moves
// in        in_valid, in_stall, in_item      one command per transfer
// out       out_valid, out_stall, out_item   one result per command
// config    psel, penable, pwrite, paddr     entry_limit at 0, timeout_seconds at 4
//
// One command at a time. Lookup and insert run the key hash, then the bucket
// remainder; lookup then walks the bucket's chain until a hit or its end, and
// insert links a new entry at the head of its bucket, or reports full. Expire
// walks every bucket and unlinks stale entries. Each result is registered.
// After reset a sweep over max(BUCKETS, FLOW_SLOTS) entries sets up the bucket
// heads and the free list; in_stall stays high meanwhile.
module flow_hash_table #(
    parameter int BUCKETS     = 256,
    parameter int FLOW_SLOTS  = 1024,
    parameter int KEY_BYTES   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fht_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output fht_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fht_pkg::*;

    logic [10:0] limit_reg;
    logic [30:0] timeout_reg;
    fht_cmd_t    cmd;
    fht_stat_t   stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_ENTRY_LIMIT)
            begin
                limit_reg <= pwdata[10:0];
            end
            else
            begin
                timeout_reg <= pwdata[30:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {1'b0, timeout_reg} : {21'd0, limit_reg};

    fht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_item.cmd),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fht_datapath #(
        .BUCKETS     (BUCKETS),
        .FLOW_SLOTS  (FLOW_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_item         (in_item),
        .cmd             (cmd),
        .entry_limit     (limit_reg),
        .timeout_seconds (timeout_reg),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_item        (out_item),
        .stat            (stat)
    );

endmodule

// ===== rtl/core/fht_ctrl.sv =====
module fht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_op,
    output logic              in_stall,
    input  fht_pkg::fht_stat_t stat,
    output fht_pkg::fht_cmd_t  cmd
);
    import fht_pkg::*;

    fht_state_t state_reg;
    fht_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (in_op == OP_LOOKUP || in_op == OP_INSERT)
                    begin
                        state_next = S_HASH;
                    end
                    else if (in_op == OP_EXPIRE)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                if (stat.op == OP_INSERT && stat.full)
                begin
                    cmd.ins_full = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                    if (stat.hash_last)
                    begin
                        cmd.step_clr = 1'b1;
                        state_next   = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (stat.op == OP_INSERT)
                begin
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.head_to_cur = 1'b1;
                if (stat.op == OP_LOOKUP)
                begin
                    state_next = stat.head_end ? S_DONE : S_LK_WALK;
                end
                else if (!stat.head_end)
                begin
                    state_next = S_EX_WALK;
                end
                else if (stat.bkt_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.bkt_inc = 1'b1;
                    state_next  = S_HEAD;
                end
            end
            S_LK_WALK:
            begin
                cmd.lk_walk = 1'b1;
                if (stat.hit || stat.next_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_INS_WRITE:
            begin
                cmd.ins_write = 1'b1;
                state_next    = S_DONE;
            end
            S_EX_WALK:
            begin
                cmd.ex_walk = 1'b1;
                if (stat.next_end)
                begin
                    if (stat.bkt_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.bkt_inc = 1'b1;
                        state_next  = S_HEAD;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/fht_datapath.sv =====
module fht_datapath #(
    parameter int BUCKETS     = 256,
    parameter int FLOW_SLOTS  = 1024,
    parameter int KEY_BYTES   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fht_pkg::in_item_t  in_item,
    input  fht_pkg::fht_cmd_t  cmd,
    input  logic [10:0]        entry_limit,
    input  logic [30:0]        timeout_seconds,
    input  logic               out_stall,
    output logic               out_valid,
    output fht_pkg::out_item_t out_item,
    output fht_pkg::fht_stat_t stat
);
    import fht_pkg::*;

    localparam int BW         = $clog2(BUCKETS);
    localparam int EW         = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int PW         = $clog2(FLOW_SLOTS + 1);
    localparam int CLR_LEN    = (BUCKETS > FLOW_SLOTS) ? BUCKETS : FLOW_SLOTS;
    localparam int CW         = $clog2(CLR_LEN);
    localparam int HASH_STEPS = (KEY_BYTES + 3) / 4;
    localparam int CMPW       = (PW > 11) ? PW : 11;
    localparam logic [127:0]  KEY_MASK = (128'd1 << (8 * KEY_BYTES)) - 128'd1;
    localparam logic [PW-1:0] END_PTR  = PW'(FLOW_SLOTS);
    // Floor of 2^32 over the bucket count; the quotient estimate is at most one short
    localparam logic [31:0]   BKT_RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));
    localparam logic [31:0]   BKT_W     = 32'(BUCKETS);

    // Four djb2-xor rounds; bytes beyond the key length are skipped
    function automatic logic [31:0] hash_round(input logic [31:0] h,
                                               input logic [127:0] key,
                                               input logic [2:0] step);
        logic [31:0] acc;
        logic [7:0]  kb;
        int          idx;
        int          j;
        acc = h;
        for (j = 0; j < 4; j++)
        begin
            idx = 4 * int'(step) + j;
            if (idx < KEY_BYTES)
            begin
                kb  = key[8 * idx +: 8];
                acc = ((acc << 5) + acc) ^ {24'd0, kb};
            end
        end
        return acc;
    endfunction

    // Item and working registers
    logic [1:0]    op_reg;
    logic [127:0]  key_reg;
    logic [47:0]   mac_reg;
    logic [31:0]   now_reg;
    logic [31:0]   hash_reg;
    logic [2:0]    step_reg;
    logic [BW-1:0] bkt_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] cur_next;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] count_reg;
    logic [EW-1:0] free_rd_reg;
    logic [EW-1:0] free_wr_reg;
    logic [PW-1:0] removed_reg;
    logic [CW-1:0] clr_reg;
    logic [1:0]    res_status_reg;
    logic [EW-1:0] res_index_reg;
    logic [47:0]   res_mac_reg;
    logic [31:0]   res_created_reg;
    logic          out_valid_reg;
    out_item_t     out_item_reg;
    logic [31:0]   mod_work_reg;

    // Memories and their read registers
    logic [PW-1:0]  head_mem    [BUCKETS];
    logic [EW-1:0]  free_mem    [FLOW_SLOTS];
    logic [127:0]   key_mem     [FLOW_SLOTS];
    logic [47:0]    mac_mem     [FLOW_SLOTS];
    logic [31:0]    created_mem [FLOW_SLOTS];
    logic [31:0]    seen_mem    [FLOW_SLOTS];
    logic [PW-1:0]  next_mem    [FLOW_SLOTS];
    logic [PW-1:0]  head_rd;
    logic [EW-1:0]  free_rd;
    logic [127:0]   key_rd;
    logic [47:0]    mac_rd;
    logic [31:0]    created_rd;
    logic [31:0]    seen_rd;
    logic [PW-1:0]  next_rd;

    logic          ent_hit;
    logic          stale;
    logic          unlink;
    logic [EW-1:0] ent_addr;
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd;
    logic          next_we;
    logic [EW-1:0] next_wa;
    logic [PW-1:0] next_wd;
    logic          free_we;
    logic [EW-1:0] free_wa;
    logic [EW-1:0] free_wd;
    logic          clr_head;
    logic          clr_free;
    logic [63:0]   mod_prod;
    logic [31:0]   mod_fold;

    // Compare and age checks on the entry being visited
    assign ent_hit  = (key_rd == key_reg);
    assign stale    = (now_reg >= seen_rd) && ((now_reg - seen_rd) > {1'b0, timeout_seconds});
    assign unlink   = cmd.ex_walk && stale;
    assign clr_head = cmd.clr_step && ({1'b0, clr_reg} < (CW + 1)'(BUCKETS));
    assign clr_free = cmd.clr_step && ({1'b0, clr_reg} < (CW + 1)'(FLOW_SLOTS));

    // Bucket remainder: quotient estimate, product, difference, one correction
    assign mod_prod = {32'd0, hash_reg} * {32'd0, BKT_RECIP};
    assign mod_fold = (mod_work_reg >= BKT_W) ? mod_work_reg - BKT_W : mod_work_reg;

    // Advance the chain pointer
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.head_to_cur)
        begin
            cur_next = head_rd;
        end
        else if ((cmd.lk_walk && !ent_hit) || cmd.ex_walk)
        begin
            cur_next = next_rd;
        end
    end

    assign ent_addr = (cur_next < END_PTR) ? cur_next[EW-1:0] : '0;

    // Select the write port of each memory
    always_comb
    begin
        head_we = 1'b0;
        head_wa = bkt_reg;
        head_wd = next_rd;
        next_we = 1'b0;
        next_wa = prev_reg[EW-1:0];
        next_wd = next_rd;
        free_we = 1'b0;
        free_wa = free_wr_reg;
        free_wd = cur_reg[EW-1:0];
        if (clr_head)
        begin
            head_we = 1'b1;
            head_wa = clr_reg[BW-1:0];
            head_wd = END_PTR;
        end
        else if (cmd.ins_write)
        begin
            head_we = 1'b1;
            head_wd = PW'(free_rd);
        end
        else if (unlink && prev_reg == END_PTR)
        begin
            head_we = 1'b1;
        end
        if (cmd.ins_write)
        begin
            next_we = 1'b1;
            next_wa = free_rd;
            next_wd = head_rd;
        end
        else if (unlink && prev_reg != END_PTR)
        begin
            next_we = 1'b1;
        end
        if (clr_free)
        begin
            free_we = 1'b1;
            free_wa = clr_reg[EW-1:0];
            free_wd = clr_reg[EW-1:0];
        end
        else if (unlink)
        begin
            free_we = 1'b1;
        end
    end

    // Bucket heads
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd <= head_mem[bkt_reg];
    end

    // Free list
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        free_rd <= free_mem[free_rd_reg];
    end

    // Entry stores, written by insert
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            key_mem[free_rd]     <= key_reg;
            mac_mem[free_rd]     <= mac_reg;
            created_mem[free_rd] <= now_reg;
            seen_mem[free_rd]    <= now_reg;
        end
        key_rd     <= key_mem[ent_addr];
        mac_rd     <= mac_mem[ent_addr];
        created_rd <= created_mem[ent_addr];
        seen_rd    <= seen_mem[ent_addr];
    end

    // Chain links
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd <= next_mem[ent_addr];
    end

    // Capture the item, run the hash, hold the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_item.cmd;
            key_reg  <= {in_item.key_high, in_item.key_low} & KEY_MASK;
            mac_reg  <= in_item.mac_present ? in_item.source_mac : 48'd0;
            now_reg  <= in_item.now_time;
            hash_reg <= HASH_SEED;
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= hash_round(hash_reg, key_reg, step_reg);
        end

        if (cmd.mod_step)
        begin
            unique case (step_reg)
                3'd0:    mod_work_reg <= mod_prod[63:32];
                3'd1:    mod_work_reg <= mod_work_reg * BKT_W;
                3'd2:    mod_work_reg <= hash_reg - mod_work_reg;
                default: mod_work_reg <= mod_work_reg;
            endcase
        end

        if (cmd.load)
        begin
            res_status_reg  <= (in_item.cmd == OP_EXPIRE) ? STAT_OK : STAT_MISS;
            res_index_reg   <= '0;
            res_mac_reg     <= '0;
            res_created_reg <= '0;
        end
        else if (cmd.ins_full)
        begin
            res_status_reg <= STAT_FULL;
        end
        else if (cmd.ins_write)
        begin
            res_status_reg  <= STAT_OK;
            res_index_reg   <= free_rd;
            res_mac_reg     <= mac_reg;
            res_created_reg <= now_reg;
        end
        else if (cmd.lk_walk && ent_hit)
        begin
            res_status_reg  <= STAT_OK;
            res_index_reg   <= cur_reg[EW-1:0];
            res_mac_reg     <= mac_rd;
            res_created_reg <= created_rd;
        end

        if (cmd.out_load)
        begin
            out_item_reg.status        <= res_status_reg;
            out_item_reg.entry_index   <= 10'(res_index_reg);
            out_item_reg.entry_mac     <= res_mac_reg;
            out_item_reg.entry_created <= res_created_reg;
            out_item_reg.live_count    <= 11'(count_reg);
            out_item_reg.removed_count <= 11'(removed_reg);
        end
    end

    // Counters, pointers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            bkt_reg       <= '0;
            cur_reg       <= END_PTR;
            prev_reg      <= END_PTR;
            count_reg     <= '0;
            free_rd_reg   <= '0;
            free_wr_reg   <= '0;
            removed_reg   <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.step_clr)
            begin
                step_reg <= '0;
            end
            else if (cmd.hash_step || cmd.mod_step)
            begin
                step_reg <= step_reg + 3'd1;
            end

            if (cmd.load)
            begin
                bkt_reg <= '0;
            end
            else if (cmd.mod_step && step_reg == 3'd3)
            begin
                bkt_reg <= mod_fold[BW-1:0];
            end
            else if (cmd.bkt_inc)
            begin
                bkt_reg <= bkt_reg + BW'(1);
            end

            cur_reg <= cur_next;
            if (cmd.head_to_cur)
            begin
                prev_reg <= END_PTR;
            end
            else if (cmd.ex_walk && !stale)
            begin
                prev_reg <= cur_reg;
            end

            if (cmd.ins_write)
            begin
                count_reg   <= count_reg + PW'(1);
                free_rd_reg <= (free_rd_reg == EW'(FLOW_SLOTS - 1)) ? '0
                                                                    : free_rd_reg + EW'(1);
            end
            else if (unlink)
            begin
                count_reg   <= count_reg - PW'(1);
                free_wr_reg <= (free_wr_reg == EW'(FLOW_SLOTS - 1)) ? '0
                                                                    : free_wr_reg + EW'(1);
            end

            if (cmd.load)
            begin
                removed_reg <= '0;
            end
            else if (unlink)
            begin
                removed_reg <= removed_reg + PW'(1);
            end

            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CW'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.hash_last = (step_reg == 3'(HASH_STEPS - 1));
        stat.mod_last  = (step_reg == 3'd3);
        stat.head_end  = (head_rd == END_PTR);
        stat.hit       = ent_hit;
        stat.next_end  = (next_rd == END_PTR);
        stat.bkt_last  = (bkt_reg == BW'(BUCKETS - 1));
        stat.full      = (CMPW'(count_reg) >= CMPW'(entry_limit)) || (count_reg == END_PTR);
        stat.out_free  = !out_valid_reg || !out_stall;
        stat.clr_last  = (clr_reg == CW'(CLR_LEN - 1));
        stat.op        = op_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
